// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the stack instruction sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== rtl/core/sics_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack instruction sequencer package
// Word types, instruction groups and constants shared by the sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package sics_pkg;

    typedef enum logic [2:0] {
        GRP_NONE = 3'd0,
        GRP_BRK  = 3'd1,
        GRP_JSR  = 3'd2,
        GRP_RTI  = 3'd3,
        GRP_RTS  = 3'd4,
        GRP_PH   = 3'd5,
        GRP_PL   = 3'd6
    } grp_t;

    localparam logic       FUNC_START = 1'b0;
    localparam logic       FUNC_CYCLE = 1'b1;

    localparam logic [1:0] OUTCOME_BUSY  = 2'd0;
    localparam logic [1:0] OUTCOME_DONE  = 2'd1;
    localparam logic [1:0] OUTCOME_ERROR = 2'd2;

    localparam logic [7:0] OP_BRK = 8'h00;
    localparam logic [7:0] OP_JSR = 8'h20;
    localparam logic [7:0] OP_RTI = 8'h40;
    localparam logic [7:0] OP_RTS = 8'h60;
    localparam logic [7:0] OP_PHP = 8'h08;
    localparam logic [7:0] OP_PHA = 8'h48;
    localparam logic [7:0] OP_PLP = 8'h28;
    localparam logic [7:0] OP_PLA = 8'h68;

    localparam logic [7:0]  STACK_PAGE = 8'h01;
    localparam logic [7:0]  BRK_FLAG   = 8'h10;
    localparam logic [15:0] IRQ_VEC    = 16'hFFFE;
    localparam logic [15:0] IRQ_VEC_HI = 16'hFFFF;

    localparam logic [2:0] CYC_FIRST = 3'd1;
    localparam logic [2:0] CYC_2     = 3'd2;
    localparam logic [2:0] CYC_3     = 3'd3;
    localparam logic [2:0] CYC_4     = 3'd4;
    localparam logic [2:0] CYC_5     = 3'd5;
    localparam logic [2:0] CYC_6     = 3'd6;
    localparam logic [2:0] CYC_7     = 3'd7;

    typedef struct packed {
        logic        func;
        logic [7:0]  opcode;
        logic [15:0] pc_in;
        logic [7:0]  sp_in;
        logic [7:0]  acc_in;
        logic [7:0]  flags_in;
        logic [7:0]  read_data;
    } cmd_t;

    typedef struct packed {
        logic [15:0] bus_addr;
        logic        bus_write;
        logic [7:0]  bus_wdata;
        logic [15:0] pc_out;
        logic [7:0]  sp_out;
        logic [7:0]  acc_out;
        logic [7:0]  flags_out;
        logic [1:0]  outcome;
    } rsp_t;

    typedef struct packed {
        logic [2:0]  cycle_number;
        grp_t        instr_group;
        logic        uses_flags_reg;
        logic [7:0]  operand_low;
        logic [7:0]  held_byte;
        logic [15:0] prog_counter;
        logic [7:0]  stack_pointer;
        logic [7:0]  accumulator;
        logic [7:0]  flags_reg;
    } state_t;

    localparam state_t STATE_RESET = '{
        cycle_number:   CYC_FIRST,
        instr_group:    GRP_NONE,
        uses_flags_reg: 1'b0,
        operand_low:    8'h00,
        held_byte:      8'h00,
        prog_counter:   16'h0000,
        stack_pointer:  8'h00,
        accumulator:    8'h00,
        flags_reg:      8'h00
    };

endpackage

`default_nettype wire

// ===== rtl/core/sics_step.sv =====
// ----------------------------------------------------------------------------
// Sequencer step
// Performs one start or bus cycle on the register state and gives the outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module sics_step (
    input  wire sics_pkg::state_t state,
    input  wire sics_pkg::cmd_t   cmd,
    output sics_pkg::state_t      state_next,
    output logic [1:0]            outcome
);
    import sics_pkg::*;

    logic [2:0] cyc;
    grp_t       grp;
    logic [7:0] rd;

    always_comb
    begin
        cyc        = state.cycle_number + 3'd1;
        grp        = state.instr_group;
        rd         = cmd.read_data;
        state_next = state;
        outcome    = OUTCOME_BUSY;
        if (cmd.func == FUNC_START)
        begin
            state_next.prog_counter   = cmd.pc_in;
            state_next.stack_pointer  = cmd.sp_in;
            state_next.accumulator    = cmd.acc_in;
            state_next.flags_reg      = cmd.flags_in;
            state_next.cycle_number   = CYC_FIRST;
            state_next.operand_low    = 8'h00;
            state_next.held_byte      = 8'h00;
            state_next.uses_flags_reg = (cmd.opcode == OP_PHP) || (cmd.opcode == OP_PLP);
            case (cmd.opcode)
                OP_BRK:         state_next.instr_group = GRP_BRK;
                OP_JSR:         state_next.instr_group = GRP_JSR;
                OP_RTI:         state_next.instr_group = GRP_RTI;
                OP_RTS:         state_next.instr_group = GRP_RTS;
                OP_PHP, OP_PHA: state_next.instr_group = GRP_PH;
                OP_PLP, OP_PLA: state_next.instr_group = GRP_PL;
                default:        state_next.instr_group = GRP_NONE;
            endcase
            if (state_next.instr_group == GRP_NONE)
            begin
                outcome = OUTCOME_ERROR;
            end
        end
        else if (grp == GRP_NONE)
        begin
            outcome = OUTCOME_ERROR;
        end
        else
        begin
            case (cyc)
                CYC_2:
                begin
                    state_next.operand_low = rd;
                    if (grp == GRP_BRK || grp == GRP_JSR)
                    begin
                        state_next.prog_counter = state.prog_counter + 16'd1;
                    end
                end
                CYC_3:
                begin
                    if (grp == GRP_BRK || grp == GRP_PH)
                    begin
                        state_next.stack_pointer = state.stack_pointer - 8'd1;
                        if (grp == GRP_PH)
                        begin
                            outcome = OUTCOME_DONE;
                        end
                    end
                    else if (grp != GRP_JSR)
                    begin
                        state_next.stack_pointer = state.stack_pointer + 8'd1;
                    end
                end
                CYC_4:
                begin
                    case (grp)
                        GRP_BRK, GRP_JSR:
                        begin
                            state_next.stack_pointer = state.stack_pointer - 8'd1;
                        end
                        GRP_RTI:
                        begin
                            state_next.flags_reg     = rd;
                            state_next.stack_pointer = state.stack_pointer + 8'd1;
                        end
                        GRP_RTS:
                        begin
                            state_next.held_byte     = rd;
                            state_next.stack_pointer = state.stack_pointer + 8'd1;
                        end
                        GRP_PL:
                        begin
                            if (state.uses_flags_reg)
                            begin
                                state_next.flags_reg = rd;
                            end
                            else
                            begin
                                state_next.accumulator = rd;
                            end
                            outcome = OUTCOME_DONE;
                        end
                        default: outcome = OUTCOME_ERROR;
                    endcase
                end
                CYC_5:
                begin
                    case (grp)
                        GRP_BRK, GRP_JSR:
                        begin
                            state_next.stack_pointer = state.stack_pointer - 8'd1;
                        end
                        GRP_RTI:
                        begin
                            state_next.held_byte     = rd;
                            state_next.stack_pointer = state.stack_pointer + 8'd1;
                        end
                        GRP_RTS: state_next.prog_counter = {rd, state.held_byte};
                        default: outcome = OUTCOME_ERROR;
                    endcase
                end
                CYC_6:
                begin
                    case (grp)
                        GRP_BRK: state_next.held_byte = rd;
                        GRP_RTI:
                        begin
                            state_next.prog_counter = {rd, state.held_byte};
                            outcome = OUTCOME_DONE;
                        end
                        GRP_RTS:
                        begin
                            state_next.prog_counter = state.prog_counter + 16'd1;
                            outcome = OUTCOME_DONE;
                        end
                        GRP_JSR:
                        begin
                            state_next.prog_counter = {rd, state.operand_low};
                            outcome = OUTCOME_DONE;
                        end
                        default: outcome = OUTCOME_ERROR;
                    endcase
                end
                CYC_7:
                begin
                    if (grp == GRP_BRK)
                    begin
                        state_next.prog_counter = {rd, state.held_byte};
                        outcome = OUTCOME_DONE;
                    end
                    else
                    begin
                        outcome = OUTCOME_ERROR;
                    end
                end
                default: outcome = OUTCOME_ERROR;
            endcase
            state_next.cycle_number = cyc;
            if (outcome != OUTCOME_BUSY)
            begin
                state_next.instr_group  = GRP_NONE;
                state_next.cycle_number = CYC_FIRST;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sics_announce.sv =====
// ----------------------------------------------------------------------------
// Sequencer bus announce
// Derives the next bus access and the register view from the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module sics_announce (
    input  wire sics_pkg::state_t state,
    input  wire [1:0]             outcome,
    output sics_pkg::rsp_t        rsp
);
    import sics_pkg::*;

    logic [3:0]  nxt;
    logic [15:0] stack_addr;
    logic [7:0]  chosen;

    always_comb
    begin
        nxt            = {1'b0, state.cycle_number} + 4'd1;
        stack_addr     = {STACK_PAGE, state.stack_pointer};
        chosen         = state.uses_flags_reg ? state.flags_reg : state.accumulator;
        rsp.bus_addr   = state.prog_counter;
        rsp.bus_write  = 1'b0;
        rsp.bus_wdata  = 8'h00;
        rsp.pc_out     = state.prog_counter;
        rsp.sp_out     = state.stack_pointer;
        rsp.acc_out    = state.accumulator;
        rsp.flags_out  = state.flags_reg;
        rsp.outcome    = outcome;
        if (state.instr_group != GRP_NONE)
        begin
            case (nxt)
                {1'b0, CYC_3}:
                begin
                    rsp.bus_addr = stack_addr;
                    if (state.instr_group == GRP_BRK)
                    begin
                        rsp.bus_write = 1'b1;
                        rsp.bus_wdata = state.prog_counter[15:8];
                    end
                    else if (state.instr_group == GRP_PH)
                    begin
                        rsp.bus_write = 1'b1;
                        rsp.bus_wdata = chosen;
                    end
                end
                {1'b0, CYC_4}:
                begin
                    rsp.bus_addr = stack_addr;
                    if (state.instr_group == GRP_BRK)
                    begin
                        rsp.bus_write = 1'b1;
                        rsp.bus_wdata = state.prog_counter[7:0];
                    end
                    else if (state.instr_group == GRP_JSR)
                    begin
                        rsp.bus_write = 1'b1;
                        rsp.bus_wdata = state.prog_counter[15:8];
                    end
                end
                {1'b0, CYC_5}:
                begin
                    rsp.bus_addr = stack_addr;
                    if (state.instr_group == GRP_BRK)
                    begin
                        rsp.bus_write = 1'b1;
                        rsp.bus_wdata = state.flags_reg | BRK_FLAG;
                    end
                    else if (state.instr_group == GRP_JSR)
                    begin
                        rsp.bus_write = 1'b1;
                        rsp.bus_wdata = state.prog_counter[7:0];
                    end
                end
                {1'b0, CYC_6}:
                begin
                    if (state.instr_group == GRP_BRK)
                    begin
                        rsp.bus_addr = IRQ_VEC;
                    end
                    else if (state.instr_group == GRP_RTI)
                    begin
                        rsp.bus_addr = stack_addr;
                    end
                end
                {1'b0, CYC_7}: rsp.bus_addr = IRQ_VEC_HI;
                default:       rsp.bus_addr = state.prog_counter;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stack_instruction_cycle_sequencer_core.sv =====
// Latency: a result word appears in the cycle after its command word is accepted.
// Throughput: one command word per clock while cmd_stall is low; the result register is the only stage.
// The command side stalls only while a held result word is itself stalled.
// Reset clears the register state to the idle condition (cycle one, no
// instruction active) and empties the result register.
// ----------------------------------------------------------------------------
// Stack instruction cycle sequencer
// Steps the stack-group instructions one bus cycle per accepted command word.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_instruction_cycle_sequencer_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_stall,
    input  wire sics_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output sics_pkg::rsp_t      rsp
);
    import sics_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] outcome;
    rsp_t       rsp_reg;
    rsp_t       rsp_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       accept;

    assign cmd_stall      = rsp_valid_reg && rsp_stall;
    assign accept         = cmd_valid && !cmd_stall;
    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    sics_step u_step (
        .state      (state_reg),
        .cmd        (cmd),
        .state_next (state_next),
        .outcome    (outcome)
    );

    sics_announce u_announce (
        .state   (state_next),
        .outcome (outcome),
        .rsp     (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sics_checker.sv =====
// ----------------------------------------------------------------------------
// Sequencer port checker
// Watches the sequencer ports for handshake and bus access consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sics_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 cmd_valid,
    input wire                 cmd_stall,
    input wire sics_pkg::cmd_t cmd,
    input wire                 rsp_valid,
    input wire                 rsp_stall,
    input wire sics_pkg::rsp_t rsp
);
    import sics_pkg::*;

    logic cmd_accept;
    logic cmd_start;

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cmd_start  = cmd_accept && (cmd.func == FUNC_START);

    `ASSERT_NEXT(a_accept_gives_word, clk, rst_n, cmd_accept, rsp_valid)

    `ASSERT_NEXT(a_held_word_stable, clk, rst_n, rsp_valid && rsp_stall,
        rsp_valid && $stable(rsp))

    `ASSERT_SAME(a_write_hits_stack, clk, rst_n, rsp_valid && rsp.bus_write,
        rsp.bus_addr[15:8] == STACK_PAGE)

    `ASSERT_SAME(a_end_fetches_pc, clk, rst_n,
        rsp_valid && (rsp.outcome != OUTCOME_BUSY),
        !rsp.bus_write && (rsp.bus_addr == rsp.pc_out))

    `ASSERT_NEXT(a_start_loads_regs, clk, rst_n, cmd_start,
        (rsp.pc_out == $past(cmd.pc_in)) && (rsp.sp_out == $past(cmd.sp_in)))

endmodule

bind stack_instruction_cycle_sequencer_core sics_checker u_sics_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack instruction cycle sequencer testbench
// Drives start and bus cycle words through the valid/stall command channel,
// predicts every result word with an independent cycle model of the stack
// group instructions and compares each accepted result field by field.
// ----------------------------------------------------------------------------

module testbench;

    import sics_pkg::*;

    localparam int ITEMS          = 1700;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_LIMIT    = 100;

    class bus_cycle_scoreboard;
        state_t st;
        rsp_t   expected_cycles[$];
        int     mismatches;
        int     checked;

        function new();
            st = STATE_RESET;
            mismatches = 0;
            checked = 0;
        endfunction

        function int pending();
            return expected_cycles.size();
        endfunction

        function rsp_t next_bus_cycle(cmd_t w);
            rsp_t        r;
            logic [2:0]  n;
            logic [15:0] stk;
            grp_t        g;
            r = '0;
            if (w.func == FUNC_START)
            begin
                st = STATE_RESET;
                st.prog_counter = w.pc_in;
                st.stack_pointer = w.sp_in;
                st.accumulator = w.acc_in;
                st.flags_reg = w.flags_in;
                case (w.opcode)
                    OP_BRK:         st.instr_group = GRP_BRK;
                    OP_JSR:         st.instr_group = GRP_JSR;
                    OP_RTI:         st.instr_group = GRP_RTI;
                    OP_RTS:         st.instr_group = GRP_RTS;
                    OP_PHP, OP_PHA: st.instr_group = GRP_PH;
                    OP_PLP, OP_PLA: st.instr_group = GRP_PL;
                    default:        st.instr_group = GRP_NONE;
                endcase
                st.uses_flags_reg = (w.opcode == OP_PHP) || (w.opcode == OP_PLP);
                r.outcome = (st.instr_group == GRP_NONE) ? OUTCOME_ERROR : OUTCOME_BUSY;
            end
            else if (st.instr_group == GRP_NONE)
            begin
                r.outcome = OUTCOME_ERROR;
            end
            else
            begin
                g = st.instr_group;
                n = st.cycle_number + 3'd1;
                r.outcome = OUTCOME_ERROR;
                case (n)
                    CYC_2:
                    begin
                        st.operand_low = w.read_data;
                        if (g == GRP_BRK || g == GRP_JSR)
                            st.prog_counter = st.prog_counter + 16'd1;
                        r.outcome = OUTCOME_BUSY;
                    end
                    CYC_3:
                    begin
                        r.outcome = (g == GRP_PH) ? OUTCOME_DONE : OUTCOME_BUSY;
                        if (g == GRP_BRK || g == GRP_PH)
                            st.stack_pointer = st.stack_pointer - 8'd1;
                        else if (g != GRP_JSR)
                            st.stack_pointer = st.stack_pointer + 8'd1;
                    end
                    CYC_4:
                    begin
                        r.outcome = OUTCOME_BUSY;
                        case (g)
                            GRP_BRK, GRP_JSR:
                                st.stack_pointer = st.stack_pointer - 8'd1;
                            GRP_RTI:
                            begin
                                st.flags_reg = w.read_data;
                                st.stack_pointer = st.stack_pointer + 8'd1;
                            end
                            GRP_RTS:
                            begin
                                st.held_byte = w.read_data;
                                st.stack_pointer = st.stack_pointer + 8'd1;
                            end
                            GRP_PL:
                            begin
                                if (st.uses_flags_reg)
                                    st.flags_reg = w.read_data;
                                else
                                    st.accumulator = w.read_data;
                                r.outcome = OUTCOME_DONE;
                            end
                            default:
                                r.outcome = OUTCOME_ERROR;
                        endcase
                    end
                    CYC_5:
                    begin
                        r.outcome = OUTCOME_BUSY;
                        case (g)
                            GRP_BRK, GRP_JSR:
                                st.stack_pointer = st.stack_pointer - 8'd1;
                            GRP_RTI:
                            begin
                                st.held_byte = w.read_data;
                                st.stack_pointer = st.stack_pointer + 8'd1;
                            end
                            GRP_RTS:
                                st.prog_counter = {w.read_data, st.held_byte};
                            default:
                                r.outcome = OUTCOME_ERROR;
                        endcase
                    end
                    CYC_6:
                    begin
                        r.outcome = OUTCOME_DONE;
                        case (g)
                            GRP_BRK:
                            begin
                                st.held_byte = w.read_data;
                                r.outcome = OUTCOME_BUSY;
                            end
                            GRP_RTI:
                                st.prog_counter = {w.read_data, st.held_byte};
                            GRP_RTS:
                                st.prog_counter = st.prog_counter + 16'd1;
                            GRP_JSR:
                                st.prog_counter = {w.read_data, st.operand_low};
                            default:
                                r.outcome = OUTCOME_ERROR;
                        endcase
                    end
                    CYC_7:
                    begin
                        if (g == GRP_BRK)
                        begin
                            st.prog_counter = {w.read_data, st.held_byte};
                            r.outcome = OUTCOME_DONE;
                        end
                    end
                    default:
                        r.outcome = OUTCOME_ERROR;
                endcase
                st.cycle_number = n;
                if (r.outcome != OUTCOME_BUSY)
                begin
                    st.instr_group = GRP_NONE;
                    st.cycle_number = CYC_FIRST;
                end
            end

            stk = {STACK_PAGE, st.stack_pointer};
            n = st.cycle_number + 3'd1;
            g = st.instr_group;
            r.bus_addr = st.prog_counter;
            if (g != GRP_NONE)
            begin
                case (n)
                    CYC_3:
                    begin
                        r.bus_addr = stk;
                        if (g == GRP_BRK)
                        begin
                            r.bus_write = 1'b1;
                            r.bus_wdata = st.prog_counter[15:8];
                        end
                        else if (g == GRP_PH)
                        begin
                            r.bus_write = 1'b1;
                            r.bus_wdata = st.uses_flags_reg ? st.flags_reg : st.accumulator;
                        end
                    end
                    CYC_4:
                    begin
                        r.bus_addr = stk;
                        if (g == GRP_BRK)
                        begin
                            r.bus_write = 1'b1;
                            r.bus_wdata = st.prog_counter[7:0];
                        end
                        else if (g == GRP_JSR)
                        begin
                            r.bus_write = 1'b1;
                            r.bus_wdata = st.prog_counter[15:8];
                        end
                    end
                    CYC_5:
                    begin
                        r.bus_addr = stk;
                        if (g == GRP_BRK)
                        begin
                            r.bus_write = 1'b1;
                            r.bus_wdata = st.flags_reg | BRK_FLAG;
                        end
                        else if (g == GRP_JSR)
                        begin
                            r.bus_write = 1'b1;
                            r.bus_wdata = st.prog_counter[7:0];
                        end
                    end
                    CYC_6:
                    begin
                        if (g == GRP_BRK)
                            r.bus_addr = IRQ_VEC;
                        else if (g == GRP_RTI)
                            r.bus_addr = stk;
                    end
                    CYC_7:
                        r.bus_addr = IRQ_VEC_HI;
                    default:
                        r.bus_addr = st.prog_counter;
                endcase
            end
            r.pc_out = st.prog_counter;
            r.sp_out = st.stack_pointer;
            r.acc_out = st.accumulator;
            r.flags_out = st.flags_reg;
            return r;
        endfunction

        function void note(cmd_t w);
            expected_cycles.push_back(next_bus_cycle(w));
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("word %0d %s got %h expected %h",
                                          checked, name, got, want));
        endtask

        task check(rsp_t got);
            rsp_t e;
            if (expected_cycles.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with none expected", got));
            end
            else
            begin
                e = expected_cycles.pop_front();
                compare_field("bus_addr", got.bus_addr, e.bus_addr);
                compare_field("bus_write", 16'(got.bus_write), 16'(e.bus_write));
                compare_field("bus_wdata", 16'(got.bus_wdata), 16'(e.bus_wdata));
                compare_field("pc_out", got.pc_out, e.pc_out);
                compare_field("sp_out", 16'(got.sp_out), 16'(e.sp_out));
                compare_field("acc_out", 16'(got.acc_out), 16'(e.acc_out));
                compare_field("flags_out", 16'(got.flags_out), 16'(e.flags_out));
                compare_field("outcome", 16'(got.outcome), 16'(e.outcome));
                checked++;
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    bus_cycle_scoreboard sb = new();

    int         send_idle = 22;
    int         recv_idle = 68;
    int         words_sent = 0;
    int         stuck_cycles = 0;
    logic       hold_tog = 1'b0;
    logic [7:0] stack_ops [8];

    stack_instruction_cycle_sequencer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic cmd_t rand_word(input logic f);
        cmd_t w;
        w.func = f;
        w.opcode = 8'($urandom);
        w.pc_in = 16'($urandom);
        w.sp_in = 8'($urandom);
        w.acc_in = 8'($urandom);
        w.flags_in = 8'($urandom);
        w.read_data = 8'($urandom);
        return w;
    endfunction

    function automatic int cycles_for(input logic [7:0] op);
        case (op)
            OP_BRK:                 return 6;
            OP_JSR, OP_RTI, OP_RTS: return 5;
            OP_PHP, OP_PHA:         return 2;
            OP_PLP, OP_PLA:         return 3;
            default:                return 0;
        endcase
    endfunction

    task automatic send_word(input cmd_t w);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note(w);
        words_sent++;
    endtask

    task automatic run_instr(input logic [7:0] op, input logic [15:0] pc,
                             input logic [7:0] sp, input logic [7:0] acc,
                             input logic [7:0] flags, input int count,
                             input bit fixed_rd, input logic [7:0] rd);
        cmd_t w;
        int   i;
        w = rand_word(FUNC_START);
        w.opcode = op;
        w.pc_in = pc;
        w.sp_in = sp;
        w.acc_in = acc;
        w.flags_in = flags;
        send_word(w);
        for (i = 0; i < count; i++)
        begin
            w = rand_word(FUNC_CYCLE);
            if (fixed_rd)
                w.read_data = rd;
            send_word(w);
        end
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic seen;
        int   k;
        rsp_stall = 1'b0;
        seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_tog != seen)
            begin
                seen = hold_tog;
                rsp_stall <= 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            rsp_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check(rsp);
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int         phase;
        int         sel;
        int         target;
        logic [7:0] op;
        cmd_t       w;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        stack_ops = '{OP_BRK, OP_JSR, OP_RTI, OP_RTS, OP_PHP, OP_PHA, OP_PLP, OP_PLA};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 22 : (phase == 1) ? 68 : 0;
            recv_idle <= (phase == 0) ? 68 : (phase == 1) ? 22 : 0;
            if (phase == 0)
            begin
                // A cycle word with no instruction active must give an error.
                send_word(rand_word(FUNC_CYCLE));
                run_instr(OP_BRK, 16'hFFFF, 8'h00, 8'hFF, 8'h00, 6, 1'b1, 8'hFF);
                run_instr(OP_JSR, 16'h0000, 8'hFF, 8'h00, 8'hFF, 5, 1'b1, 8'h00);
                run_instr(OP_RTS, 16'h1234, 8'hFF, 8'h55, 8'hAA, 5, 1'b1, 8'hFF);
                run_instr(OP_PHP, 16'h8000, 8'h00, 8'h00, 8'hFF, 2, 1'b1, 8'h00);
                run_instr(OP_PLA, 16'h7FFF, 8'hFF, 8'hFF, 8'h00, 3, 1'b1, 8'h00);
                run_instr(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1, 1'b1, 8'hFF);
                hold_tog <= ~hold_tog;
            end
            target = (phase + 1) * ITEMS / 3;
            while (words_sent < target)
            begin
                sel = $urandom_range(99);
                op = stack_ops[3'($urandom_range(7))];
                if (sel < 75)
                begin
                    run_instr(op, 16'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), cycles_for(op), 1'b0, 8'h00);
                end
                else if (sel < 87)
                begin
                    run_instr(op, 16'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), $urandom_range(cycles_for(op) - 1),
                              1'b0, 8'h00);
                end
                else if (sel < 94)
                begin
                    run_instr(8'($urandom), 16'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), $urandom_range(1),
                              1'b0, 8'h00);
                end
                else
                begin
                    w = rand_word(FUNC_CYCLE);
                    send_word(w);
                end
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sics_pkg.sv
rtl/core/sics_step.sv
rtl/core/sics_announce.sv
rtl/core/stack_instruction_cycle_sequencer_core.sv
rtl/core/sics_checker.sv
verif/testbench.sv
